@@ design/hcts_pkg.sv @@
// Package for the hall capture timing and stall detect block.
// Holds the transaction payload types, register codes and fixed constants.
// No dependencies.
`default_nettype none

package hcts_pkg;

  // Input transaction codes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_TICK_WRAP_PERIOD = 2'd0;
  localparam logic [1:0] CFG_SLOW_SPEED_TICKS = 2'd1;
  localparam logic [1:0] CFG_STALL_TICKS      = 2'd2;

  // Register reset values
  localparam logic [14:0] TICK_WRAP_RESET  = 15'd10000;
  localparam logic [14:0] SLOW_SPEED_RESET = 15'd100;
  localparam logic [14:0] STALL_RESET      = 15'd1000;

  // Velocity time base codes
  localparam logic [1:0] VSRC_NONE  = 2'd0;
  localparam logic [1:0] VSRC_TIMER = 2'd1;
  localparam logic [1:0] VSRC_TICK  = 2'd2;

  // Five-step slot sequence
  localparam logic [2:0] SLOT_COMMUTATION = 3'd1;
  localparam logic [2:0] SLOT_VELOCITY    = 3'd2;
  localparam logic [2:0] SLOT_COUNT       = 3'd5;

  localparam logic [14:0] GAP_MAX = 15'h7fff;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  capture_flags;
    logic [15:0] capture_time;
  } in_item_t;

  typedef struct packed {
    logic        capture_valid;
    logic [1:0]  channel;
    logic [15:0] edge_delta;
    logic [15:0] previous_edge_delta;
    logic [14:0] tick_delta;
    logic [1:0]  velocity_source;
    logic        stall_res;
    logic        commutation_slot;
    logic        velocity_slot;
    logic        blink_pulse;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [14:0] wdata;
  } cfg_wr_t;

  // Configuration as seen by the core
  typedef struct packed {
    logic [14:0] tick_wrap_period;
    logic [14:0] slow_speed_ticks;
    logic [14:0] stall_ticks;
  } cfg_regs_t;

endpackage

`default_nettype wire

@@ design/hcts_stream_if.sv @@
// Valid/ready channel interface carrying one payload type.
// Used for the input, result and configuration channels with hcts_pkg payload types.
`default_nettype none

interface hcts_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/hcts_core.sv @@
// Timing state and per-item datapath: tick/slot counters, edge stores, gap.
// Depends on hcts_pkg.
`default_nettype none

module hcts_core #(
  parameter int CHANNELS = 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hcts_pkg::cfg_regs_t cfg,
  input  wire hcts_pkg::in_item_t  item,
  input  wire logic               step,
  output hcts_pkg::out_item_t      res
);

  // Only three flag bits exist
  localparam int NUM_ACT = (CHANNELS < 3) ? CHANNELS : 3;
  localparam int CH_W    = (NUM_ACT > 1) ? $clog2(NUM_ACT) : 1;

  logic [15:0] tick_cnt_r, tick_cnt_nxt;
  logic [2:0]  slot_r, slot_nxt;
  logic [15:0] tick_edge_r, tick_edge_nxt;
  logic [15:0] edge_store_r [NUM_ACT];
  logic [15:0] delta_new_r  [NUM_ACT];

  logic          hit;
  logic [CH_W-1:0] sel;
  logic signed [17:0] gap_raw, gap_fix;
  logic [14:0]   gap;
  logic [14:0]   wrap_eff;
  logic [15:0]   tick_inc;
  logic [2:0]    slot_inc;
  logic [15:0]   delta_cur;
  logic          do_tick, do_cap;

  // Ticks since the last valid edge, wrap corrected and clamped
  always_comb begin
    gap_raw = $signed({2'b00, tick_cnt_r}) - $signed({2'b00, tick_edge_r});
    gap_fix = gap_raw[17] ? (gap_raw + $signed({3'b000, cfg.tick_wrap_period})) : gap_raw;
    if (gap_fix[17]) begin
      gap = '0;
    end else if (gap_fix[16:15] != 2'b00) begin
      gap = hcts_pkg::GAP_MAX;
    end else begin
      gap = gap_fix[14:0];
    end
  end

  // Lowest flagged channel wins
  always_comb begin
    hit = 1'b0;
    sel = '0;
    for (int i = NUM_ACT - 1; i >= 0; i--) begin
      if (item.capture_flags[i]) begin
        hit = 1'b1;
        sel = CH_W'(i);
      end
    end
  end

  assign delta_cur = item.capture_time - edge_store_r[sel];
  assign do_tick   = step && (item.opcode == hcts_pkg::OP_TICK);
  assign do_cap    = step && (item.opcode == hcts_pkg::OP_CAPTURE) && hit;

  // Counter advance on a tick, edge tick capture on a capture
  always_comb begin
    wrap_eff = (cfg.tick_wrap_period == '0) ? 15'd1 : cfg.tick_wrap_period;
    tick_inc = tick_cnt_r + 16'd1;
    slot_inc = slot_r + 3'd1;
    tick_cnt_nxt  = tick_cnt_r;
    slot_nxt      = slot_r;
    tick_edge_nxt = tick_edge_r;
    if (do_tick) begin
      tick_cnt_nxt = (tick_inc >= {1'b0, wrap_eff}) ? 16'd0 : tick_inc;
      slot_nxt     = (slot_inc >= hcts_pkg::SLOT_COUNT) ? 3'd0 : slot_inc;
    end
    if (do_cap) begin
      tick_edge_nxt = tick_cnt_r;
    end
  end

  // Result fields
  always_comb begin
    res = '0;
    if (item.opcode == hcts_pkg::OP_TICK) begin
      res.tick_delta       = gap;
      res.stall_res        = ({1'b0, gap} > {1'b0, cfg.stall_ticks});
      res.commutation_slot = (slot_inc == hcts_pkg::SLOT_COMMUTATION);
      res.velocity_slot    = (slot_inc == hcts_pkg::SLOT_VELOCITY);
      res.blink_pulse      = (tick_inc >= {1'b0, wrap_eff});
    end else if (hit) begin
      res.capture_valid       = 1'b1;
      res.channel             = 2'(sel) + 2'd1;
      res.edge_delta          = delta_cur;
      res.previous_edge_delta = delta_new_r[sel];
      res.tick_delta          = gap;
      res.velocity_source     = (gap > cfg.slow_speed_ticks) ? hcts_pkg::VSRC_TICK
                                                              : hcts_pkg::VSRC_TIMER;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r  <= '0;
      slot_r      <= '0;
      tick_edge_r <= '0;
      for (int i = 0; i < NUM_ACT; i++) begin
        edge_store_r[i] <= '0;
        delta_new_r[i]  <= '0;
      end
    end else begin
      tick_cnt_r  <= tick_cnt_nxt;
      slot_r      <= slot_nxt;
      tick_edge_r <= tick_edge_nxt;
      for (int i = 0; i < NUM_ACT; i++) begin
        if (do_cap && (sel == CH_W'(i))) begin
          edge_store_r[i] <= item.capture_time;
          delta_new_r[i]  <= delta_cur;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ design/hall_capture_timing_stall_detect_top.sv @@
// Top level of the hall capture timing and stall detect block.
// Uses hcts_pkg, hcts_stream_if and hcts_core.
//
// Channels: in_if carries one transaction per item, a control tick
// (opcode 0) or a capture event (opcode 1, lowest set flag picks the
// channel). out_if returns exactly one result transaction per item.
// cfg_if writes tick_wrap_period (0), slow_speed_ticks (1) and
// stall_ticks (2); it is always ready and should only be used while idle.
// Flow: an accepted item is registered in the input register, processed
// by the core when it advances, and its result registered for out_if.
// Throughput: one item per cycle while out_if.ready stays high; counters and
// edge stores update in one core pass between input and result register.
// Reset (rst_n low, synchronous): counters, edge stores and both pipeline
// stages clear; registers return to 10000 / 100 / 1000.
// Stall: while out_if.ready is low the result holds, the input register
// keeps one more item, and in_if.ready drops once both stages are full.
`default_nettype none

module hall_capture_timing_stall_detect_top #(
  parameter int CHANNELS = 3
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hcts_stream_if.sink   in_if,
  hcts_stream_if.source out_if,
  hcts_stream_if.sink   cfg_if
);

  hcts_pkg::cfg_regs_t cfg_r;
  logic                s1_valid_r;
  hcts_pkg::in_item_t  s1_item_r;
  logic                out_valid_r;
  hcts_pkg::out_item_t out_item_r;
  hcts_pkg::out_item_t core_res;
  logic                s1_adv;

  // Configuration writes
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_wrap_period <= hcts_pkg::TICK_WRAP_RESET;
      cfg_r.slow_speed_ticks <= hcts_pkg::SLOW_SPEED_RESET;
      cfg_r.stall_ticks      <= hcts_pkg::STALL_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.payload.reg_index)
        hcts_pkg::CFG_TICK_WRAP_PERIOD: cfg_r.tick_wrap_period <= cfg_if.payload.wdata;
        hcts_pkg::CFG_SLOW_SPEED_TICKS: cfg_r.slow_speed_ticks <= cfg_if.payload.wdata;
        hcts_pkg::CFG_STALL_TICKS:      cfg_r.stall_ticks      <= cfg_if.payload.wdata;
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_item_r <= in_if.payload;
    end
    if (s1_adv) begin
      out_item_r <= core_res;
    end
  end

  hcts_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .item  (s1_item_r),
    .step  (s1_adv),
    .res   (core_res)
  );

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_item_r;

  // Checks
  a_cap_fields : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.capture_valid |->
      (out_item_r.channel != 2'd0) && (out_item_r.velocity_source != hcts_pkg::VSRC_NONE)
      && !out_item_r.stall_res && !out_item_r.blink_pulse)
    else $error("capture result carries tick fields or no channel");

  a_slot_excl : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({out_item_r.commutation_slot, out_item_r.velocity_slot,
              out_item_r.capture_valid}) || !out_valid_r)
    else $error("slot flags overlap");

  a_adv_out : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("processed item produced no result");

  a_no_cap_no_vsrc : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.capture_valid |->
      (out_item_r.velocity_source == hcts_pkg::VSRC_NONE) && (out_item_r.channel == 2'd0))
    else $error("velocity source set without a capture");

endmodule

`default_nettype wire

@@ tb/tb_hall_capture_timing_stall_detect_top.sv @@
// Self-checking testbench for hall_capture_timing_stall_detect_top.
// Needs hcts_pkg, hcts_stream_if and the RTL of the block; a built-in timing
// predictor checks every result transaction against the expected one.

module tb_hall_capture_timing_stall_detect_top;

  localparam int          NUM_CH       = 3;
  localparam int          CLK_HALF     = 6;
  localparam int          MAX_CYCLES   = 600000;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          PRINT_LIMIT  = 40;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;

  logic clk;
  logic rst_n;

  hcts_stream_if #(.payload_t(hcts_pkg::in_item_t))  in_ch  ();
  hcts_stream_if #(.payload_t(hcts_pkg::out_item_t)) out_ch ();
  hcts_stream_if #(.payload_t(hcts_pkg::cfg_wr_t))   cfg_ch ();

  hall_capture_timing_stall_detect_top #(.CHANNELS(NUM_CH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Predictor state: counters, edge stores and register copy
  hcts_pkg::cfg_regs_t model_cfg;
  logic [15:0] tick_count;
  logic [2:0]  slot_count;
  logic [15:0] tick_at_edge;
  logic [15:0] edge_stamp   [NUM_CH];
  logic [15:0] delta_newest [NUM_CH];
  logic [15:0] delta_prior  [NUM_CH];

  hcts_pkg::out_item_t pending_timing_results[$];

  // Run bookkeeping
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned results_seen;
  int unsigned n_ticks, n_captures, n_no_channel, n_stalls, n_blinks, n_tick_base;
  bit          no_idle;
  int unsigned ready_hold;
  hcts_pkg::out_item_t got_res, want_res;

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_timing_results.size());
      $display("[hall_capture_timing_stall_detect_top] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d field %s got 0x%0h want 0x%0h",
                                results_seen, name, got, want));
  endtask

  function automatic void clear_timing_state();
    model_cfg.tick_wrap_period = hcts_pkg::TICK_WRAP_RESET;
    model_cfg.slow_speed_ticks = hcts_pkg::SLOW_SPEED_RESET;
    model_cfg.stall_ticks      = hcts_pkg::STALL_RESET;
    tick_count   = '0;
    slot_count   = '0;
    tick_at_edge = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      edge_stamp[i]   = '0;
      delta_newest[i] = '0;
      delta_prior[i]  = '0;
    end
  endfunction

  // Ticks since the last valid edge, wrap corrected and clamped to 15 bits
  function automatic logic [14:0] ticks_since_edge();
    int d;
    d = int'(tick_count) - int'(tick_at_edge);
    if (d < 0)
      d += int'(model_cfg.tick_wrap_period);
    if (d < 0)
      d = 0;
    if (d > int'(hcts_pkg::GAP_MAX))
      d = int'(hcts_pkg::GAP_MAX);
    return d[14:0];
  endfunction

  // Expected result of one input transaction; advances the predictor state
  function automatic hcts_pkg::out_item_t predict_timing(input hcts_pkg::in_item_t it);
    hcts_pkg::out_item_t r;
    logic [15:0] wrap_eff;
    logic [14:0] gap;
    int          ch;
    r = '0;
    if (it.opcode == hcts_pkg::OP_TICK) begin
      n_ticks++;
      gap = ticks_since_edge();
      r.tick_delta = gap;
      r.stall_res  = (gap > model_cfg.stall_ticks);
      wrap_eff = (model_cfg.tick_wrap_period == '0) ? 16'd1 : {1'b0, model_cfg.tick_wrap_period};
      tick_count = tick_count + 16'd1;
      slot_count = slot_count + 3'd1;
      if (slot_count == hcts_pkg::SLOT_COMMUTATION)
        r.commutation_slot = 1'b1;
      else if (slot_count == hcts_pkg::SLOT_VELOCITY)
        r.velocity_slot = 1'b1;
      else if (slot_count >= hcts_pkg::SLOT_COUNT)
        slot_count = '0;
      if (tick_count >= wrap_eff) begin
        r.blink_pulse = 1'b1;
        tick_count    = '0;
      end
      if (r.stall_res) n_stalls++;
      if (r.blink_pulse) n_blinks++;
    end else begin
      n_captures++;
      ch = 0;
      for (int i = 0; i < NUM_CH; i++) begin
        if (it.capture_flags[i] && ch == 0)
          ch = i + 1;
      end
      if (ch == 0) begin
        n_no_channel++;
      end else begin
        delta_prior[ch-1]  = delta_newest[ch-1];
        delta_newest[ch-1] = it.capture_time - edge_stamp[ch-1];
        edge_stamp[ch-1]   = it.capture_time;
        gap = ticks_since_edge();
        tick_at_edge = tick_count;
        r.capture_valid       = 1'b1;
        r.channel             = 2'(ch);
        r.edge_delta          = delta_newest[ch-1];
        r.previous_edge_delta = delta_prior[ch-1];
        r.tick_delta          = gap;
        r.velocity_source     = (gap > model_cfg.slow_speed_ticks) ? hcts_pkg::VSRC_TICK
                                                                   : hcts_pkg::VSRC_TIMER;
        if (r.velocity_source == hcts_pkg::VSRC_TICK) n_tick_base++;
      end
    end
    return r;
  endfunction

  // Result side: random stall of ready after each taken result, none while no_idle is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (no_idle || $urandom_range(0, 14) == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        ready_hold   <= $urandom_range(0, 13);
      end
    end else if (!out_ch.ready) begin
      if (ready_hold == 0)
        out_ch.ready <= 1'b1;
      else
        ready_hold <= ready_hold - 1;
    end
  end

  // Result checker: each transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_timing_results.size() == 0) begin
        report_mismatch("result transaction with no expected result");
      end else begin
        want_res = pending_timing_results.pop_front();
        got_res  = out_ch.payload;
        check_field("capture_valid", got_res.capture_valid, want_res.capture_valid);
        check_field("channel", got_res.channel, want_res.channel);
        check_field("edge_delta", got_res.edge_delta, want_res.edge_delta);
        check_field("previous_edge_delta", got_res.previous_edge_delta,
                    want_res.previous_edge_delta);
        check_field("tick_delta", got_res.tick_delta, want_res.tick_delta);
        check_field("velocity_source", got_res.velocity_source, want_res.velocity_source);
        check_field("stall_res", got_res.stall_res, want_res.stall_res);
        check_field("commutation_slot", got_res.commutation_slot,
                    want_res.commutation_slot);
        check_field("velocity_slot", got_res.velocity_slot, want_res.velocity_slot);
        check_field("blink_pulse", got_res.blink_pulse, want_res.blink_pulse);
      end
      results_seen++;
    end
  end

  // One input transaction with a random lead-in gap; valid stays high after
  task automatic send_item(input hcts_pkg::in_item_t it);
    int unsigned pause;
    pause = no_idle ? 0 : $urandom_range(0, 14);
    if (pause != 0) begin
      in_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_timing_results.push_back(predict_timing(it));
  endtask

  function automatic hcts_pkg::in_item_t tick_item(input logic [2:0] flags,
                                                   input logic [15:0] etime);
    hcts_pkg::in_item_t it;
    it.opcode        = hcts_pkg::OP_TICK;
    it.capture_flags = flags;
    it.capture_time  = etime;
    return it;
  endfunction

  function automatic hcts_pkg::in_item_t capture_item(input logic [2:0] flags,
                                                      input logic [15:0] etime);
    hcts_pkg::in_item_t it;
    it.opcode        = hcts_pkg::OP_CAPTURE;
    it.capture_flags = flags;
    it.capture_time  = etime;
    return it;
  endfunction

  // Hold off until every expected result is back and the block is quiet
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_timing_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{reg_index: idx, wdata: val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      hcts_pkg::CFG_TICK_WRAP_PERIOD: model_cfg.tick_wrap_period = val;
      hcts_pkg::CFG_SLOW_SPEED_TICKS: model_cfg.slow_speed_ticks = val;
      hcts_pkg::CFG_STALL_TICKS:      model_cfg.stall_ticks      = val;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [14:0] wrap, input logic [14:0] slow,
                            input logic [14:0] stall);
    wait_idle();
    write_reg(hcts_pkg::CFG_TICK_WRAP_PERIOD, wrap);
    write_reg(hcts_pkg::CFG_SLOW_SPEED_TICKS, slow);
    write_reg(hcts_pkg::CFG_STALL_TICKS, stall);
  endtask

  // Channel priority, timer delta wrap and the no-flag case at reset settings
  task automatic test_capture_basics();
    send_item(capture_item(3'b001, 16'h0000));
    send_item(capture_item(3'b001, 16'hffff));
    send_item(capture_item(3'b001, 16'h0001));
    send_item(capture_item(3'b000, 16'h1234));
    send_item(capture_item(3'b110, 16'h8000));
    send_item(capture_item(3'b100, 16'h7fff));
    send_item(capture_item(3'b111, 16'haaaa));
    send_item(capture_item(3'b010, 16'h5555));
  endtask

  // Five-step slot sequence; capture fields of a tick are ignored
  task automatic test_tick_slots();
    repeat (6) send_item(tick_item(3'b111, 16'hffff));
    send_item(capture_item(3'b001, 16'h0000));
  endtask

  // Short wrap, stall flag, lowered period, negative gap and zero period
  task automatic test_wrap_and_gap();
    set_config(15'd12, 15'd2, 15'd3);
    repeat (10) send_item(tick_item(3'b000, 16'h0000));
    send_item(capture_item(3'b100, 16'h4321));
    set_config(15'd2, 15'd2, 15'd3);
    repeat (2) send_item(tick_item(3'b101, 16'h00ff));
    set_config(15'd0, 15'd2, 15'd3);
    repeat (2) send_item(tick_item(3'b010, 16'hff00));
  endtask

  // Random mix of ticks and captures under the current settings
  task automatic run_random_phase(input int n_items, input int capture_pct);
    hcts_pkg::in_item_t it;
    for (int i = 0; i < n_items; i++) begin
      if (i % 64 == 0)
        no_idle = ($urandom_range(0, 3) == 0);
      if (i > 0 && i % 250 == 0)
        wait_idle();
      it.opcode        = ($urandom_range(0, 99) < capture_pct) ? hcts_pkg::OP_CAPTURE
                                                               : hcts_pkg::OP_TICK;
      it.capture_flags = 3'($urandom_range(0, 7));
      it.capture_time  = 16'($urandom);
      send_item(it);
    end
    no_idle = 1'b0;
  endtask

  // Several register settings, both extremes among them
  task automatic test_random_traffic();
    set_config(15'd1, 15'd0, 15'd0);
    run_random_phase(350, 30);
    set_config(15'h7fff, 15'h7fff, 15'h7fff);
    run_random_phase(350, 40);
    wait_idle();
    write_reg(CFG_UNUSED, 15'($urandom));
    set_config(15'd40, 15'd8, 15'd20);
    run_random_phase(400, 15);
    set_config(15'($urandom_range(2, 200)), 15'($urandom_range(0, 30)),
               15'($urandom_range(0, 60)));
    run_random_phase(450, 10);
    set_config(15'($urandom_range(1, 32767)), 15'($urandom_range(0, 32767)),
               15'($urandom_range(0, 32767)));
    run_random_phase(450, 25);
  endtask

  // Main sequence
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    no_idle        = 1'b0;
    ready_hold     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    results_seen   = 0;
    n_ticks = 0; n_captures = 0; n_no_channel = 0;
    n_stalls = 0; n_blinks = 0; n_tick_base = 0;
    clear_timing_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_capture_basics();
    test_tick_slots();
    test_wrap_and_gap();
    test_random_traffic();
    wait_idle();

    $display("covered %0d ticks and %0d captures (%0d with no channel), %0d results checked",
             n_ticks, n_captures, n_no_channel, results_seen);
    $display("seen %0d stall flags, %0d blink pulses, %0d tick-based velocity picks",
             n_stalls, n_blinks, n_tick_base);
    if (mismatch_count == 0) begin
      $display("[hall_capture_timing_stall_detect_top] OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[hall_capture_timing_stall_detect_top] ERROR");
    end
    $finish;
  end

endmodule

@@ hall_capture_timing_stall_detect_top.f @@
design/hcts_pkg.sv
design/hcts_stream_if.sv
design/hcts_core.sv
design/hall_capture_timing_stall_detect_top.sv
tb/tb_hall_capture_timing_stall_detect_top.sv
